@@ hw/rtl/pcpa_pkg.sv @@
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types, codes and defaults for the per-CPU page allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

  localparam int DEF_NUM_CPUS  = 4;
  localparam int DEF_NUM_PAGES = 1024;
  localparam int DEF_REF_BITS  = 8;

  localparam int PAGE_W   = 10;
  localparam int ACTION_W = 3;
  localparam int CPU_W    = 2;
  localparam int STATUS_W = 3;
  localparam int RC_W     = 8;
  localparam int FREE_W   = 11;

  localparam logic [ACTION_W-1:0] ACT_INIT    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ADDREF  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_INSPECT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREE_UNREF = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ADD_UNREF = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OOM       = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDREF,
    S_EXEC,
    S_INIT,
    S_POP,
    S_FIND,
    S_WALK,
    S_STEAL,
    S_STEAL2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [PAGE_W-1:0] addr;
    logic [PAGE_W-1:0] wdata;
  } link_req_t;

endpackage

@@ hw/rtl/per_cpu_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_unit
// Per-CPU LIFO page allocator with reference counts.
// ----------------------------------------------------------------------------
// Requests are taken one at a time while busy is low. The result strobe lasts
// one cycle and cannot be stalled, so the receiver must take every result.
// After reset busy stays high while the count memory is cleared one page a
// cycle. An alloc from a non-empty list runs link read, pop and result; free,
// addref and inspect run count read, update and result, and skip the update
// when the page is out of range; an unknown action goes straight to the result.
// Init writes at most one link and one count per cycle. An alloc that steals
// walks the victim list one link a cycle and moves take = (len+1)/2 pages of
// the victim list, where the victim is the nearest non-empty list in ring
// order; an alloc that finds every list empty tries each of the other lists
// in turn and then reports out of memory.
module per_cpu_page_allocator_unit
  import pcpa_pkg::*;
#(
  parameter int NUM_CPUS  = DEF_NUM_CPUS,
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int REF_BITS  = DEF_REF_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [CPU_W-1:0]    in_cpu,
  input  logic [PAGE_W-1:0]   in_page,
  output logic                out_strobe,
  output logic [PAGE_W-1:0]   out_result_page,
  output logic                out_granted,
  output logic                out_released,
  output logic [STATUS_W-1:0] out_status,
  output logic [RC_W-1:0]     out_ref_count,
  output logic [FREE_W-1:0]   out_free_pages,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PAGE_W-1:0]   cfg_first_usable_page
);

  localparam int AW  = $clog2(NUM_PAGES);
  localparam int LW  = $clog2(NUM_PAGES + 1);
  localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

  state_t state_r, state_nxt;

  logic [PAGE_W-1:0]   fup_r;
  logic [AW-1:0]       head_r [NUM_CPUS];
  logic [LW-1:0]       len_r  [NUM_CPUS];
  logic [LW-1:0]       total_r;

  logic [ACTION_W-1:0] act_r;
  logic [CW-1:0]       cpu_r;
  logic [PAGE_W-1:0]   page_r;
  logic [CW-1:0]       vic_r;
  logic [CW:0]         off_r;
  logic [LW-1:0]       cnt_r, take_r;
  logic [AW-1:0]       tail_r, first_r;
  logic [AW:0]         sweep_r;
  logic                clr_done_r;

  logic [PAGE_W-1:0]   o_page_r;
  logic                o_gr_r, o_rel_r;
  logic [STATUS_W-1:0] o_st_r;
  logic [REF_BITS-1:0] o_rc_r;

  link_req_t           lwr;
  logic [AW-1:0]       lrd_addr, lrd_data;
  logic                rwe;
  logic [AW-1:0]       rwa, rra;
  logic [REF_BITS-1:0] rwd, rrd;

  pcpa_link_mem #(.NUM_PAGES(NUM_PAGES)) u_link (
    .clk(clk), .wr(lwr), .rd_addr(lrd_addr), .rd_data(lrd_data)
  );

  pcpa_ref_mem #(.NUM_PAGES(NUM_PAGES), .REF_BITS(REF_BITS)) u_ref (
    .clk(clk), .we(rwe), .wr_addr(rwa), .wr_data(rwd), .rd_addr(rra), .rd_data(rrd)
  );

  function automatic logic [CW-1:0] wrap_cpu(input logic [CPU_W-1:0] c);
    int v;
    v = int'(c);
    for (int i = 0; i < (1 << CPU_W); i++) begin
      if (v >= NUM_CPUS) v = v - NUM_CPUS;
    end
    return CW'(v);
  endfunction

  logic accept;
  logic page_ok;
  logic [CW-1:0] cpu_in;
  logic [CW-1:0] cand;
  logic [31:0]   cand_sum;

  assign busy      = (state_r != S_IDLE) || !clr_done_r;
  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign cpu_in    = wrap_cpu(in_cpu);
  assign page_ok   = (page_r >= fup_r) && (32'(page_r) < NUM_PAGES);
  assign cand_sum  = 32'(cpu_r) + 32'(off_r);
  assign cand      = CW'((cand_sum >= 32'(NUM_CPUS)) ? cand_sum - 32'(NUM_CPUS) : cand_sum);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_INIT:  state_nxt = S_INIT;
            ACT_ALLOC: state_nxt = S_POP;
            ACT_FREE, ACT_ADDREF, ACT_INSPECT: state_nxt = S_RDREF;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_RDREF:  state_nxt = page_ok ? S_EXEC : S_DONE;
      S_EXEC:   state_nxt = S_DONE;
      S_INIT:   state_nxt = (32'(cnt_r) >= NUM_PAGES - 1) ? S_DONE : S_INIT;
      S_POP:    state_nxt = (len_r[cpu_r] != '0) ? S_DONE : S_FIND;
      S_FIND: begin
        if (32'(off_r) >= NUM_CPUS) state_nxt = S_DONE;
        else if (len_r[cand] != '0) state_nxt = S_WALK;
      end
      S_WALK:   state_nxt = (cnt_r >= take_r) ? S_STEAL : S_WALK;
      S_STEAL:  state_nxt = S_STEAL2;
      S_STEAL2: state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // memory ports
  always_comb begin
    lwr      = '0;
    lrd_addr = head_r[cpu_r];
    rwe      = 1'b0;
    rwa      = page_r[AW-1:0];
    rwd      = '0;
    rra      = in_page[AW-1:0];
    if (!clr_done_r) begin
      rwe = 1'b1;
      rwa = sweep_r[AW-1:0];
    end
    unique case (state_r)
      S_IDLE: begin
        lrd_addr = head_r[cpu_in];
      end
      S_RDREF: begin
        rra = page_r[AW-1:0];
      end
      S_INIT: begin
        rwe       = (32'(cnt_r) >= 32'(fup_r));
        rwa       = cnt_r[AW-1:0];
        lwr.we    = rwe && (32'(cnt_r) > 32'(fup_r));
        lwr.addr  = PAGE_W'(cnt_r);
        lwr.wdata = PAGE_W'(cnt_r - LW'(1));
      end
      S_POP: begin
        lrd_addr = head_r[cpu_r];
      end
      S_FIND: begin
        lrd_addr = head_r[cand];
      end
      S_WALK: begin
        lrd_addr = lrd_data;
      end
      S_STEAL: begin
        lrd_addr = first_r;
        lwr.we    = (take_r > LW'(1));
        lwr.addr  = PAGE_W'(tail_r);
        lwr.wdata = PAGE_W'(head_r[cpu_r]);
      end
      S_EXEC: begin
        if (act_r == ACT_FREE && rrd != '0) begin
          rwe = 1'b1;
          rwd = rrd - REF_ONE;
          if (rrd == REF_ONE) begin
            lwr.we    = 1'b1;
            lwr.addr  = page_r;
            lwr.wdata = PAGE_W'(head_r[cpu_r]);
          end
        end else if (act_r == ACT_ADDREF && rrd != '0 && rrd != REF_MAX) begin
          rwe = 1'b1;
          rwd = rrd + REF_ONE;
        end
      end
      S_DONE: begin
        if (act_r == ACT_ALLOC && o_gr_r) begin
          rwe = 1'b1;
          rwa = o_page_r[AW-1:0];
          rwd = REF_ONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fup_r      <= '0;
      sweep_r    <= '0;
      clr_done_r <= 1'b0;
      out_strobe <= 1'b0;
      total_r    <= '0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        head_r[i] <= '0;
        len_r[i]  <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      out_strobe <= (state_r == S_DONE);
      if (!clr_done_r) begin
        sweep_r <= sweep_r + 1'b1;
        if (32'(sweep_r) == NUM_PAGES - 1) clr_done_r <= 1'b1;
      end
      if (cfg_valid && cfg_ready) fup_r <= cfg_first_usable_page;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            act_r    <= in_action;
            cpu_r    <= cpu_in;
            page_r   <= in_page;
            o_page_r <= in_page;
            o_gr_r   <= 1'b0;
            o_rel_r  <= 1'b0;
            o_st_r   <= ST_OK;
            o_rc_r   <= '0;
            off_r    <= (CW+1)'(1);
            cnt_r    <= '0;
            if (in_action == ACT_INIT) begin
              for (int i = 0; i < NUM_CPUS; i++) begin
                head_r[i] <= '0;
                len_r[i]  <= '0;
              end
              total_r <= '0;
            end
          end
        end
        S_RDREF: begin
          if (!page_ok) o_st_r <= ST_RANGE;
        end
        S_EXEC: begin
          o_rc_r <= rrd;
          if (act_r == ACT_FREE) begin
            if (rrd == '0) o_st_r <= ST_FREE_UNREF;
            else begin
              o_rc_r <= rrd - REF_ONE;
              if (rrd == REF_ONE) begin
                o_rel_r        <= 1'b1;
                head_r[cpu_r]  <= page_r[AW-1:0];
                len_r[cpu_r]   <= len_r[cpu_r] + 1'b1;
                total_r        <= total_r + 1'b1;
              end
            end
          end else if (act_r == ACT_ADDREF) begin
            if (rrd == '0) o_st_r <= ST_ADD_UNREF;
            else if (rrd == REF_MAX) o_st_r <= ST_OVERFLOW;
            else o_rc_r <= rrd + REF_ONE;
          end
        end
        S_INIT: begin
          cnt_r <= cnt_r + 1'b1;
          if (32'(cnt_r) >= 32'(fup_r)) begin
            head_r[cpu_r] <= cnt_r[AW-1:0];
            len_r[cpu_r]  <= len_r[cpu_r] + 1'b1;
            total_r       <= total_r + 1'b1;
          end
        end
        S_POP: begin
          if (len_r[cpu_r] != '0) begin
            o_page_r      <= PAGE_W'(head_r[cpu_r]);
            o_gr_r        <= 1'b1;
            o_rc_r        <= REF_ONE;
            head_r[cpu_r] <= lrd_data;
            len_r[cpu_r]  <= len_r[cpu_r] - 1'b1;
            total_r       <= total_r - 1'b1;
          end
        end
        S_FIND: begin
          if (32'(off_r) >= NUM_CPUS) begin
            o_page_r <= '0;
            o_st_r   <= ST_OOM;
          end else if (len_r[cand] != '0) begin
            vic_r   <= cand;
            take_r  <= LW'((32'(len_r[cand]) + 1) / 2);
            first_r <= head_r[cand];
            tail_r  <= head_r[cand];
            cnt_r   <= LW'(1);
          end else begin
            off_r <= off_r + 1'b1;
          end
        end
        S_WALK: begin
          if (cnt_r < take_r) begin
            tail_r <= lrd_data;
            cnt_r  <= cnt_r + 1'b1;
          end else begin
            head_r[vic_r] <= lrd_data;
            len_r[vic_r]  <= len_r[vic_r] - take_r;
          end
        end
        S_STEAL: begin
          o_page_r <= PAGE_W'(first_r);
          o_gr_r   <= 1'b1;
          o_rc_r   <= REF_ONE;
          total_r  <= total_r - 1'b1;
        end
        S_STEAL2: begin
          if (take_r > LW'(1)) begin
            head_r[cpu_r] <= lrd_data;
            len_r[cpu_r]  <= len_r[cpu_r] + take_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_result_page <= o_page_r;
      out_granted     <= o_gr_r;
      out_released    <= o_rel_r;
      out_status      <= o_st_r;
      out_ref_count   <= RC_W'(o_rc_r);
      out_free_pages  <= FREE_W'(total_r);
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !accept) else $error("request accepted while busy");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> state_r == S_IDLE) else $error("strobe outside idle");
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_granted |-> out_status == ST_OK) else $error("grant with error");

endmodule

@@ hw/rtl/pcpa_link_mem.sv @@
// ----------------------------------------------------------------------------
// pcpa_link_mem
// Link table: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pcpa_link_mem
  import pcpa_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int AW = $clog2(NUM_PAGES)
) (
  input  logic          clk,
  input  link_req_t     wr,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_data
);

  logic [AW-1:0] mem [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr[AW-1:0]] <= wr.wdata[AW-1:0];
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/pcpa_ref_mem.sv @@
// ----------------------------------------------------------------------------
// pcpa_ref_mem
// Reference count table: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pcpa_ref_mem
  import pcpa_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int REF_BITS  = DEF_REF_BITS,
  parameter int AW = $clog2(NUM_PAGES)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       wr_addr,
  input  logic [REF_BITS-1:0] wr_data,
  input  logic [AW-1:0]       rd_addr,
  output logic [REF_BITS-1:0] rd_data
);

  logic [REF_BITS-1:0] mem [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ tb/tb_per_cpu_page_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_cpu_page_allocator_unit
// Self-checking bench for the per-CPU page allocator. A behavioral copy of the
// free lists, links and reference counts predicts every result; a monitor
// compares each strobed result with the oldest prediction. Directed requests
// cover range limits, misuse, overflow, stealing and out of memory; random
// phases mix alloc/free/addref traffic under several first-page settings.
// ----------------------------------------------------------------------------
module tb_per_cpu_page_allocator_unit;
  import pcpa_pkg::*;

  localparam int NCPU   = DEF_NUM_CPUS;
  localparam int NPAGE  = DEF_NUM_PAGES;
  localparam int REFMAX = (1 << DEF_REF_BITS) - 1;
  localparam int LIMIT  = 4000000;

  typedef struct packed {
    logic [PAGE_W-1:0]   page;
    logic                granted;
    logic                released;
    logic [STATUS_W-1:0] status;
    logic [RC_W-1:0]     rc;
    logic [FREE_W-1:0]   free_cnt;
  } alloc_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] in_action;
  logic [CPU_W-1:0]    in_cpu;
  logic [PAGE_W-1:0]   in_page;
  logic                out_strobe;
  logic [PAGE_W-1:0]   out_result_page;
  logic                out_granted;
  logic                out_released;
  logic [STATUS_W-1:0] out_status;
  logic [RC_W-1:0]     out_ref_count;
  logic [FREE_W-1:0]   out_free_pages;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [PAGE_W-1:0]   cfg_first_usable_page;

  per_cpu_page_allocator_unit dut (.*);

  // predictor state
  logic [PAGE_W-1:0] mdl_link [NPAGE];
  logic [PAGE_W-1:0] mdl_head [NCPU];
  int                mdl_len  [NCPU];
  int                mdl_refs [NPAGE];
  int                mdl_first;

  alloc_result_t pending_q[$];
  int errors;
  int cycles;
  int sent;
  int checked;
  int grants;
  int steals;
  int idle_pct;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int exp_v);
    errors++;
    $display("[%0t] %s mismatch: got %0d expected %0d", $realtime, what, got, exp_v);
  endtask

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_strobe) begin
      checked++;
      if (pending_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        e = pending_q.pop_front();
        if (out_result_page !== e.page) report("result_page", out_result_page, e.page);
        if (out_granted !== e.granted) report("granted", out_granted, e.granted);
        if (out_released !== e.released) report("released", out_released, e.released);
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_ref_count !== e.rc) report("ref_count", out_ref_count, e.rc);
        if (out_free_pages !== e.free_cnt) report("free_pages", out_free_pages, e.free_cnt);
      end
    end
  end

  function automatic void mdl_push(int c, int p);
    mdl_link[p] = mdl_head[c];
    mdl_head[c] = p[PAGE_W-1:0];
    mdl_len[c]++;
  endfunction

  function automatic bit mdl_take(int c, output int got);
    int d, take, tail, first;
    if (mdl_len[c] != 0) begin
      got = mdl_head[c];
      mdl_head[c] = mdl_link[got];
      mdl_len[c]--;
      return 1;
    end
    for (int off = 1; off < NCPU; off++) begin
      d = (c + off) % NCPU;
      if (mdl_len[d] == 0) continue;
      steals++;
      take = (mdl_len[d] + 1) / 2;
      first = mdl_head[d];
      tail = first;
      for (int i = 1; i < take; i++) tail = mdl_link[tail];
      mdl_head[d] = mdl_link[tail];
      mdl_len[d] -= take;
      if (take > 1) begin
        mdl_link[tail] = mdl_head[c];
        mdl_head[c] = mdl_link[first];
        mdl_len[c] += take - 1;
      end
      got = first;
      return 1;
    end
    got = 0;
    return 0;
  endfunction

  function automatic alloc_result_t predict_allocator(logic [ACTION_W-1:0] act,
                                                      int c, int pg);
    alloc_result_t r;
    int got, tot;
    r = '0;
    r.page = pg[PAGE_W-1:0];
    case (act)
      ACT_INIT: begin
        for (int i = 0; i < NCPU; i++) begin
          mdl_head[i] = '0;
          mdl_len[i] = 0;
        end
        for (int p = mdl_first; p < NPAGE; p++) begin
          mdl_refs[p] = 0;
          mdl_push(c, p);
        end
      end
      ACT_ALLOC: begin
        if (mdl_take(c, got)) begin
          mdl_refs[got] = 1;
          r.page = got[PAGE_W-1:0];
          r.granted = 1'b1;
          r.rc = 1;
        end else begin
          r.page = '0;
          r.status = ST_OOM;
        end
      end
      ACT_FREE, ACT_ADDREF, ACT_INSPECT: begin
        if (pg < mdl_first) r.status = ST_RANGE;
        else begin
          if (act == ACT_FREE) begin
            if (mdl_refs[pg] == 0) r.status = ST_FREE_UNREF;
            else begin
              mdl_refs[pg]--;
              if (mdl_refs[pg] == 0) begin
                mdl_push(c, pg);
                r.released = 1'b1;
              end
            end
          end else if (act == ACT_ADDREF) begin
            if (mdl_refs[pg] == 0) r.status = ST_ADD_UNREF;
            else if (mdl_refs[pg] >= REFMAX) r.status = ST_OVERFLOW;
            else mdl_refs[pg]++;
          end
          r.rc = mdl_refs[pg][RC_W-1:0];
        end
      end
      default: ;
    endcase
    tot = 0;
    for (int i = 0; i < NCPU; i++) tot += mdl_len[i];
    r.free_cnt = tot[FREE_W-1:0];
    return r;
  endfunction

  task automatic send_request(logic [ACTION_W-1:0] act, int c, int pg);
    @(posedge clk);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) @(posedge clk);
    start     <= 1'b1;
    in_action <= act;
    in_cpu    <= c[CPU_W-1:0];
    in_page   <= pg[PAGE_W-1:0];
    do @(posedge clk); while (busy);
    pending_q.push_back(predict_allocator(act, c, pg));
    if (act == ACT_ALLOC && pending_q[$].granted) grants++;
    sent++;
    start <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_first_page(int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_first_usable_page <= v[PAGE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    mdl_first = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    // only a few pages in the pool so stealing and out of memory come quickly
    write_first_page(1018);
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_INIT, 1, 1023);
    send_request(ACT_INSPECT, 0, 1017);
    send_request(ACT_INSPECT, 0, 0);
    send_request(ACT_FREE, 2, 1020);
    send_request(ACT_ADDREF, 3, 1023);
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_ALLOC, 2, 0);
    send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_ADDREF, 0, 1023);
    send_request(ACT_FREE, 3, 1023);
    send_request(ACT_FREE, 3, 1023);
    send_request(ACT_FREE, 3, 1023);
    send_request(3'd5, 1, 1023);
    send_request(3'd6, 2, 0);
    send_request(3'd7, 3, 512);
    for (int i = 0; i < 8; i++) send_request(ACT_ALLOC, i % NCPU, 0);
    send_request(ACT_FREE, 0, 1018);
  endtask

  task automatic test_overflow();
    int pg;
    write_first_page(0);
    send_request(ACT_INIT, 2, 0);
    send_request(ACT_ALLOC, 2, 0);
    pg = pending_q[$].page;
    for (int i = 0; i < REFMAX + 1; i++) send_request(ACT_ADDREF, 1, pg);
    send_request(ACT_INSPECT, 0, pg);
  endtask

  task automatic test_random(int n, int first);
    int held[$];
    int act, c, pg, k;
    write_first_page(first);
    send_request(ACT_INIT, $urandom_range(NCPU - 1, 0), $urandom_range(NPAGE - 1, 0));
    for (int i = 0; i < n; i++) begin
      act = $urandom_range(99, 0);
      c = $urandom_range(NCPU - 1, 0);
      pg = $urandom_range(NPAGE - 1, 0);
      if (act < 40) begin
        send_request(ACT_ALLOC, c, pg);
        if (pending_q[$].granted) held.push_back(pending_q[$].page);
      end else if (act < 70 && held.size() != 0) begin
        k = $urandom_range(held.size() - 1, 0);
        send_request(ACT_FREE, c, held[k]);
        if (pending_q[$].released) held.delete(k);
      end else if (act < 82 && held.size() != 0) begin
        send_request(ACT_ADDREF, c, held[$urandom_range(held.size() - 1, 0)]);
      end else if (act < 90) begin
        send_request(ACT_INSPECT, c, pg);
      end else if (act < 97) begin
        send_request(ACTION_W'($urandom_range(3, 2)), c, pg);
      end else if (act < 99) begin
        send_request(ACTION_W'($urandom_range(7, 5)), c, pg);
      end else begin
        send_request(ACT_INIT, c, pg);
        held.delete();
      end
    end
  endtask

  initial begin
    errors = 0; cycles = 0; sent = 0; checked = 0; grants = 0; steals = 0;
    idle_pct = 0;
    rst_n = 1'b0; start = 1'b0; in_action = '0; in_cpu = '0; in_page = '0;
    cfg_valid = 1'b0; cfg_first_usable_page = '0;
    mdl_first = 0;
    for (int i = 0; i < NCPU; i++) begin
      mdl_head[i] = '0;
      mdl_len[i] = 0;
    end
    for (int i = 0; i < NPAGE; i++) begin
      mdl_link[i] = '0;
      mdl_refs[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    idle_pct = 0;
    test_random(265, 1000);
    idle_pct = 59;
    test_random(265, 0);
    idle_pct = 17;
    test_random(265, 1023);
    idle_pct = 0;
    test_random(265, 700);
    drain();
    $display("sent %0d requests, checked %0d results", sent, checked);
    $display("grants %0d, steals %0d", grants, steals);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pcpa_pkg.sv
hw/rtl/pcpa_link_mem.sv
hw/rtl/pcpa_ref_mem.sv
hw/rtl/per_cpu_page_allocator_unit.sv
tb/tb_per_cpu_page_allocator_unit.sv
